// File: design/qslerp_pkg.sv
`timescale 1ns / 1ps
package qslerp_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int ONE          = 1 << FRAC_BITS;
	localparam int CW           = 34;
	localparam int QDEPTH       = 4;
	localparam int QAW          = $clog2(QDEPTH);
	localparam int QCW          = $clog2(QDEPTH + 1);

	localparam logic signed [CW-1:0] KINV_Q30 = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_SMALL [11] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133524135,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576
	};

	typedef struct packed {
		logic signed [15:0] a_real;
		logic signed [15:0] a_vx;
		logic signed [15:0] a_vy;
		logic signed [15:0] a_vz;
		logic signed [15:0] b_real;
		logic signed [15:0] b_vx;
		logic signed [15:0] b_vy;
		logic signed [15:0] b_vz;
		logic [14:0]        fraction;
	} req_t;

	typedef struct packed {
		logic signed [15:0] out_real;
		logic signed [15:0] out_vx;
		logic signed [15:0] out_vy;
		logic signed [15:0] out_vz;
		logic               passed_through;
	} res_t;

	typedef struct packed {
		logic [3:0][15:0]   qa;
		logic [3:0][16:0]   qb;
		logic [FRAC_BITS:0] u;
		logic [FRAC_BITS:0] c;
	} item_t;

	typedef struct packed {
		logic           full;
		logic           nonempty;
		logic [QCW-1:0] count;
	} qstat_t;

	function automatic logic signed [CW-1:0] atan_q30(input int i);
		if (i < 11) begin
			return ATAN_SMALL[i];
		end else if (i <= 30) begin
			return $signed(CW'(1) << (30 - i));
		end
		return '0;
	endfunction

endpackage

// File: design/quaternion_slerp_top.sv
`timescale 1ns / 1ps
// Spherical linear interpolation between two unit quaternions A and B.
// Request channel: req_valid / req_stall with payload req (A, B, fraction).
// Result channel: res_valid / res_stall with payload res (interpolated
// quaternion, saturated, and passed_through when A is returned as is).
// A request is taken at a clock edge with valid high and stall low.
// Throughput: one request per cycle while req_stall is low.
// Path from request to res_valid: 2 front stages, 1 queue stage, a 32-stage
// square root, a vectoring CORDIC for the angle, a multiply/angle pair,
// three rotation CORDIC lanes for the sines, a product/sum pair and a
// 17-stage divider, then the result register.
// The front stages and a 4-entry queue keep taking requests while a result
// waits; the back pipeline holds as a whole while res_valid and res_stall
// are both high; req_stall rises on a full queue with front stage 2 valid.
// Reset clears all valid bits and the queue; no request is in flight after.
module quaternion_slerp_top #(
	parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  qslerp_pkg::req_t  req,
	output logic              res_valid,
	input  logic              res_stall,
	output qslerp_pkg::res_t  res
);

	logic               push, pop;
	qslerp_pkg::item_t  wr_item, rd_item;
	qslerp_pkg::qstat_t qstat;

	qslerp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.qstat     (qstat),
		.item      (wr_item)
	);

	qslerp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	qslerp_back #(
		.STEPS (CORDIC_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qstat.nonempty),
		.item       (rd_item),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
		else $error("queue count did not advance on push");
`endif

endmodule

// File: design/qslerp_front.sv
`timescale 1ns / 1ps
module qslerp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  qslerp_pkg::req_t     req,
	output logic                 push,
	input  qslerp_pkg::qstat_t   qstat,
	output qslerp_pkg::item_t    item
);

	localparam int FB = qslerp_pkg::FRAC_BITS;

	logic                  en;
	logic                  v_s1, v_s2;
	logic signed [31:0]    prod_s1 [4];
	logic [3:0][15:0]      qa_s1;
	logic [3:0][16:0]      qb_s1;
	logic [FB:0]           u_s1;
	qslerp_pkg::item_t     item_s2;
	logic [3:0][15:0]      a_w, b_w;
	logic signed [33:0]    raw, raw_abs, c_full;
	logic                  neg;

	assign a_w = {req.a_vz, req.a_vy, req.a_vx, req.a_real};
	assign b_w = {req.b_vz, req.b_vy, req.b_vx, req.b_real};

	assign en        = !(v_s2 && qstat.full);
	assign req_stall = !en;
	assign push      = v_s2 && !qstat.full;
	assign item      = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= $signed(a_w[i]) * $signed(b_w[i]);
				qb_s1[i]   <= {b_w[i][15], b_w[i]};
			end
			qa_s1 <= a_w;
			u_s1  <= (int'(req.fraction) > qslerp_pkg::ONE) ? (FB+1)'(qslerp_pkg::ONE)
				: (FB+1)'(req.fraction);
		end
	end

	always_comb begin
		raw = '0;
		for (int i = 0; i < 4; i++) begin
			raw = raw + 34'(prod_s1[i]);
		end
		neg     = raw[33];
		raw_abs = neg ? -raw : raw;
		c_full  = raw_abs >>> FB;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.qa <= qa_s1;
			for (int i = 0; i < 4; i++) begin
				item_s2.qb[i] <= neg ? 17'(-$signed(qb_s1[i])) : qb_s1[i];
			end
			item_s2.u <= u_s1;
			item_s2.c <= (c_full > 34'(qslerp_pkg::ONE)) ? (FB+1)'(qslerp_pkg::ONE)
				: c_full[FB:0];
		end
	end

endmodule

// File: design/qslerp_queue.sv
`timescale 1ns / 1ps
module qslerp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qslerp_pkg::item_t   wr_item,
	input  logic                pop,
	output qslerp_pkg::item_t   rd_item,
	output qslerp_pkg::qstat_t  qstat
);

	localparam int QAW = qslerp_pkg::QAW;
	localparam int QCW = qslerp_pkg::QCW;

	qslerp_pkg::item_t mem_q [qslerp_pkg::QDEPTH];
	logic [QAW-1:0]    wr_q, rd_q;
	logic [QCW-1:0]    count_q;

	assign rd_item        = mem_q[rd_q];
	assign qstat.count    = count_q;
	assign qstat.full     = (count_q == QCW'(qslerp_pkg::QDEPTH));
	assign qstat.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= QAW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= QAW'(rd_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= QCW'(count_q + 1'b1);
				2'b01:   count_q <= QCW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/qslerp_back.sv
`timescale 1ns / 1ps
module qslerp_back #(
	parameter int STEPS = qslerp_pkg::CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  qslerp_pkg::item_t  item,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output qslerp_pkg::res_t   res
);

	localparam int FB      = qslerp_pkg::FRAC_BITS;
	localparam int CW      = qslerp_pkg::CW;
	localparam int NW      = CW + 18;
	localparam int ST_ROOT = 1;
	localparam int ST_VEC  = ST_ROOT + 32;
	localparam int ST_MUL  = ST_VEC + STEPS + 1;
	localparam int ST_ANG  = ST_MUL + 1;
	localparam int ST_SIN  = ST_ANG + STEPS;
	localparam int ST_PROD = ST_SIN + 1;
	localparam int ST_SUM  = ST_PROD + 1;
	localparam int ST_DIV0 = ST_SUM + 1;
	localparam int DEPTH   = ST_DIV0 + 16;
	localparam logic signed [CW-1:0] SMALL_LIM = CW'(1) << (30 - FB);

	logic en;
	logic res_valid_q;
	qslerp_pkg::res_t res_q, res_next;

	logic              vld_s  [1:DEPTH];
	qslerp_pkg::item_t side_s [1:DEPTH];

	logic [30:0] c30;
	logic [61:0] csq;
	logic [63:0] rn_s [ST_ROOT:ST_VEC];
	logic [63:0] rr_s [ST_ROOT:ST_VEC];
	logic [30:0] rc_s [ST_ROOT:ST_VEC];

	logic signed [CW-1:0] vx_s [ST_VEC+1:ST_VEC+STEPS];
	logic signed [CW-1:0] vy_s [ST_VEC+1:ST_VEC+STEPS];
	logic signed [CW-1:0] vz_s [ST_VEC+1:ST_VEC+STEPS];

	logic signed [CW-1:0]    theta_w;
	logic signed [CW-1:0]    mul_theta_s;
	logic signed [CW+FB+1:0] mul_prod_s;
	logic signed [CW-1:0]    ang_th_s, ang_ta_s, ang_tb_s;
	logic                    ang_small_s;
	logic signed [CW-1:0]    z0 [3];

	logic signed [CW-1:0] sx_s [3][ST_ANG+1:ST_SIN];
	logic signed [CW-1:0] sy_s [3][ST_ANG+1:ST_SIN];
	logic signed [CW-1:0] sz_s [3][ST_ANG+1:ST_SIN];
	logic                 sm_s [ST_ANG+1:ST_SIN];

	logic signed [CW+16:0] pa_s [4];
	logic signed [CW+16:0] pb_s [4];
	logic signed [CW-1:0]  prod_st_s;
	logic                  prod_flag_s;
	logic signed [NW-1:0]  num_s [4];
	logic signed [CW-1:0]  sum_st_s;
	logic                  sum_flag_s;

	logic [NW-1:0] dr_s [4][ST_DIV0:DEPTH];
	logic [15:0]   dq_s [4][ST_DIV0:DEPTH];
	logic          dn_s [4][ST_DIV0:DEPTH];
	logic          dv_s [4][ST_DIV0:DEPTH];
	logic [CW-1:0] dst_s  [ST_DIV0:DEPTH];
	logic          dflag_s [ST_DIV0:DEPTH];

	assign en        = !res_valid_q || !res_stall;
	assign pop       = en && item_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[1] <= item_valid;
			for (int k = 2; k <= DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			res_valid_q <= vld_s[DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= item;
			for (int k = 2; k <= DEPTH; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign c30 = 31'(item.c) << (30 - FB);
	assign csq = c30 * c30;

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s[ST_ROOT] <= (64'd1 << 60) - 64'(csq);
			rr_s[ST_ROOT] <= '0;
			rc_s[ST_ROOT] <= c30;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (2 * (31 - j));
		logic [63:0] trial;
		assign trial = rr_s[ST_ROOT+j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_s[ST_ROOT+j] >= trial) begin
					rn_s[ST_ROOT+j+1] <= rn_s[ST_ROOT+j] - trial;
					rr_s[ST_ROOT+j+1] <= (rr_s[ST_ROOT+j] >> 1) + BIT;
				end else begin
					rn_s[ST_ROOT+j+1] <= rn_s[ST_ROOT+j];
					rr_s[ST_ROOT+j+1] <= rr_s[ST_ROOT+j] >> 1;
				end
				rc_s[ST_ROOT+j+1] <= rc_s[ST_ROOT+j];
			end
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_vec
		localparam logic signed [CW-1:0] AT = qslerp_pkg::atan_q30(j);
		logic signed [CW-1:0] xi, yi, zi;
		if (j == 0) begin : g_first
			assign xi = $signed(CW'(rc_s[ST_VEC]));
			assign yi = $signed(CW'(rr_s[ST_VEC]));
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[ST_VEC+j];
			assign yi = vy_s[ST_VEC+j];
			assign zi = vz_s[ST_VEC+j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi > 0) begin
					vx_s[ST_VEC+j+1] <= xi + (yi >>> j);
					vy_s[ST_VEC+j+1] <= yi - (xi >>> j);
					vz_s[ST_VEC+j+1] <= zi + AT;
				end else begin
					vx_s[ST_VEC+j+1] <= xi - (yi >>> j);
					vy_s[ST_VEC+j+1] <= yi + (xi >>> j);
					vz_s[ST_VEC+j+1] <= zi - AT;
				end
			end
		end
	end

	assign theta_w = (vz_s[ST_VEC+STEPS] < 0) ? '0 : vz_s[ST_VEC+STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			mul_theta_s <= theta_w;
			mul_prod_s  <= $signed({1'b0, side_s[ST_MUL-1].u}) * theta_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_th_s    <= mul_theta_s;
			ang_tb_s    <= CW'(mul_prod_s >>> FB);
			ang_ta_s    <= mul_theta_s - CW'(mul_prod_s >>> FB);
			ang_small_s <= (mul_theta_s < SMALL_LIM);
		end
	end

	assign z0[0] = ang_th_s;
	assign z0[1] = ang_ta_s;
	assign z0[2] = ang_tb_s;

	for (genvar l = 0; l < 3; l++) begin : g_lane
		for (genvar j = 0; j < STEPS; j++) begin : g_sin
			localparam logic signed [CW-1:0] AT = qslerp_pkg::atan_q30(j);
			logic signed [CW-1:0] xi, yi, zi;
			if (j == 0) begin : g_first
				assign xi = qslerp_pkg::KINV_Q30;
				assign yi = '0;
				assign zi = z0[l];
			end else begin : g_next
				assign xi = sx_s[l][ST_ANG+j];
				assign yi = sy_s[l][ST_ANG+j];
				assign zi = sz_s[l][ST_ANG+j];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						sx_s[l][ST_ANG+j+1] <= xi - (yi >>> j);
						sy_s[l][ST_ANG+j+1] <= yi + (xi >>> j);
						sz_s[l][ST_ANG+j+1] <= zi - AT;
					end else begin
						sx_s[l][ST_ANG+j+1] <= xi + (yi >>> j);
						sy_s[l][ST_ANG+j+1] <= yi - (xi >>> j);
						sz_s[l][ST_ANG+j+1] <= zi + AT;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s[ST_ANG+1] <= ang_small_s;
			for (int k = ST_ANG + 2; k <= ST_SIN; k++) begin
				sm_s[k] <= sm_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pa_s[i] <= sy_s[1][ST_SIN] * $signed(side_s[ST_PROD-1].qa[i]);
				pb_s[i] <= sy_s[2][ST_SIN] * $signed(side_s[ST_PROD-1].qb[i]);
			end
			prod_st_s   <= sy_s[0][ST_SIN];
			prod_flag_s <= sm_s[ST_SIN] || (sy_s[0][ST_SIN] <= 0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				num_s[i] <= NW'(pa_s[i]) + NW'(pb_s[i]);
			end
			sum_st_s   <= prod_st_s;
			sum_flag_s <= prod_flag_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				dn_s[i][ST_DIV0] <= num_s[i][NW-1];
				dv_s[i][ST_DIV0] <= (num_s[i][NW-1] ? NW'(-num_s[i]) : NW'(num_s[i]))
					>= (NW'(sum_st_s) << 16);
			end
			dst_s[ST_DIV0]   <= sum_st_s;
			dflag_s[ST_DIV0] <= sum_flag_s;
			for (int k = ST_DIV0 + 1; k <= DEPTH; k++) begin
				dst_s[k]   <= dst_s[k-1];
				dflag_s[k] <= dflag_s[k-1];
				for (int i = 0; i < 4; i++) begin
					dn_s[i][k] <= dn_s[i][k-1];
					dv_s[i][k] <= dv_s[i][k-1];
				end
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dr_s[i][ST_DIV0] <= num_s[i][NW-1] ? NW'(-num_s[i]) : NW'(num_s[i]);
				dq_s[i][ST_DIV0] <= '0;
			end
		end
		for (genvar j = 0; j < 16; j++) begin : g_bit
			logic [NW-1:0] dsub;
			assign dsub = NW'(dst_s[ST_DIV0+j]) << (15 - j);
			always_ff @(posedge clk) begin
				if (en) begin
					if (dr_s[i][ST_DIV0+j] >= dsub) begin
						dr_s[i][ST_DIV0+j+1] <= dr_s[i][ST_DIV0+j] - dsub;
						dq_s[i][ST_DIV0+j+1] <= dq_s[i][ST_DIV0+j] | (16'd1 << (15 - j));
					end else begin
						dr_s[i][ST_DIV0+j+1] <= dr_s[i][ST_DIV0+j];
						dq_s[i][ST_DIV0+j+1] <= dq_s[i][ST_DIV0+j];
					end
				end
			end
		end
	end

	always_comb begin
		logic [15:0] val [4];
		logic [15:0] q;
		for (int i = 0; i < 4; i++) begin
			q = dq_s[i][DEPTH];
			if (dn_s[i][DEPTH]) begin
				val[i] = (dv_s[i][DEPTH] || q > 16'd32768) ? 16'h8000 : 16'(~q + 16'd1);
			end else begin
				val[i] = (dv_s[i][DEPTH] || q > 16'd32767) ? 16'h7fff : q;
			end
			if (dflag_s[DEPTH]) begin
				val[i] = side_s[DEPTH].qa[i];
			end
		end
		res_next.out_real       = $signed(val[0]);
		res_next.out_vx         = $signed(val[1]);
		res_next.out_vy         = $signed(val[2]);
		res_next.out_vz         = $signed(val[3]);
		res_next.passed_through = dflag_s[DEPTH];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_next;
		end
	end

endmodule
